/* sv/dks_pkg.sv */
// dks_pkg: word types, controller states and command/status bundles
// shared by the descending key sorter modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dks_pkg;

    localparam int KEY_W = 16;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last_item;
    } in_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic             last_result;
        logic             dropped;
    } out_word_t;

    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } dks_state_t;

    typedef struct packed {
        logic ins;   // insert the input key into the cell chain
        logic pop;   // move the top cell into the output register
    } dks_cmd_t;

    typedef struct packed {
        logic full;      // every cell holds a key
        logic one_left;  // at most the top cell holds a key
        logic out_free;  // output register can take a word this cycle
    } dks_stat_t;

endpackage

`default_nettype wire

/* sv/dks_ctrl.sv */
// dks_ctrl: load/drain controller of the descending key sorter
// depends on dks_pkg
`timescale 1ns / 1ps
`default_nettype none

module dks_ctrl
    import dks_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      last_item,
    input  wire dks_stat_t stat,
    output logic           s_ready,
    output dks_cmd_t       cmd
);

    dks_state_t state_reg;
    dks_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid && last_item) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (stat.out_free && stat.one_left) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                cmd.ins = s_valid;
            end
            ST_DRAIN: begin
                cmd.pop = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/dks_dpath.sv */
// dks_dpath: sorted cell chain, overflow flag and output register
// depends on dks_pkg
`timescale 1ns / 1ps
`default_nettype none

module dks_dpath
    import dks_pkg::*;
#(
    parameter int MAX_KEYS = 32,
    parameter int KEY_BITS = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dks_cmd_t  cmd,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic      m_ready,
    output dks_stat_t      stat,
    output logic           m_valid,
    output out_word_t      m_data
);

    logic [KEY_BITS-1:0] cell_reg [MAX_KEYS];
    logic [KEY_BITS-1:0] cell_next [MAX_KEYS];
    logic [KEY_BITS-1:0] up_val [MAX_KEYS];
    logic [KEY_BITS-1:0] dn_val [MAX_KEYS];
    logic [MAX_KEYS-1:0] valid_reg;
    logic [MAX_KEYS-1:0] valid_next;
    logic [MAX_KEYS-1:0] ge;
    logic                overflow_reg;
    logic                overflow_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    out_word_t           m_data_reg;
    out_word_t           m_data_next;
    logic [KEY_W+KEY_BITS-1:0] key_wide;
    logic [KEY_BITS-1:0]       key_ext;
    logic [KEY_BITS+KEY_W-1:0] top_wide;

    // keys are held at KEY_BITS; bits above are ignored
    assign key_wide = {{KEY_BITS{1'b0}}, key};
    assign key_ext  = key_wide[KEY_BITS-1:0];
    assign top_wide = {{KEY_W{1'b0}}, cell_reg[0]};

    assign stat.full     = valid_reg[MAX_KEYS-1];
    assign stat.one_left = !valid_reg[1];
    assign stat.out_free = !m_valid_reg || m_ready;

    // neighbor values for shifting down (insert) and up (pop)
    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
        assign ge[i] = valid_reg[i] && (cell_reg[i] >= key_ext);
        if (i == 0) begin : g_first
            assign up_val[i] = key_ext;
        end else begin : g_rest
            assign up_val[i] = ge[i-1] ? key_ext : cell_reg[i-1];
        end
        if (i == MAX_KEYS - 1) begin : g_tail
            assign dn_val[i] = cell_reg[i];
        end else begin : g_body
            assign dn_val[i] = cell_reg[i+1];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_KEYS; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.ins && !stat.full) begin
                if (!ge[i]) begin
                    cell_next[i] = up_val[i];
                end
            end else if (cmd.pop) begin
                cell_next[i] = dn_val[i];
            end
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        overflow_next = overflow_reg;
        if (cmd.ins) begin
            if (stat.full) begin
                overflow_next = 1'b1;
            end else begin
                valid_next = {valid_reg[MAX_KEYS-2:0], 1'b1};
            end
        end else if (cmd.pop) begin
            valid_next = {1'b0, valid_reg[MAX_KEYS-1:1]};
            if (stat.one_left) begin
                overflow_next = 1'b0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.pop) begin
            m_valid_next           = 1'b1;
            m_data_next.sorted_key = top_wide[KEY_W-1:0];
            m_data_next.last_result = stat.one_left;
            m_data_next.dropped    = overflow_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_KEYS; i++) begin
            cell_reg[i] <= cell_next[i];
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_ins_and_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins && cmd.pop))
        else $error("insert and pop in the same cycle");

    a_pop_needs_key: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> valid_reg[0])
        else $error("pop from an empty cell chain");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop && stat.one_left) |=> (valid_reg == '0))
        else $error("cells still valid after the last word of a set");

    a_overflow_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(overflow_reg) |-> $past(valid_reg[MAX_KEYS-1]))
        else $error("overflow flagged while cells were free");
`endif

endmodule

`default_nettype wire

/* sv/descending_key_sorter.sv */
// a key is taken each cycle in the load state; the word flagged last closes
// the set and moves the controller to the drain state, which pops the top cell
// into the output register whenever that register is free; the single chain
// never inserts and shifts out at once, so a new set waits for the last pop
// reset: aresetn low at a clock edge empties the chain, clears the dropped
// flag and the output valid; cell contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module descending_key_sorter
    import dks_pkg::*;
#(
    parameter int MAX_KEYS = 32,
    parameter int KEY_BITS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data
);

    // command and status between controller and datapath
    dks_cmd_t  cmd;
    dks_stat_t stat;

    // controller: load state takes keys, drain state streams them out
    dks_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .last_item (s_data.last_item),
        .stat      (stat),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    // datapath: cells kept in descending order on every insert, so the
    // largest key always sits in the top cell and drains first
    dks_dpath #(
        .MAX_KEYS (MAX_KEYS),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .key     (s_data.key),
        .m_ready (m_ready),
        .stat    (stat),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* dv/descending_key_sorter_tb.sv */
// descending_key_sorter_tb: self-checking bench for the descending key sorter
// drives key sets through the valid/ready input, predicts each sorted set and
// checks every output word in order; depends on dks_pkg and descending_key_sorter
`timescale 1ns / 1ps

module descending_key_sorter_tb;

    import dks_pkg::*;

    localparam int SET_CAP     = 32;     // store capacity of the dut
    localparam int TARGET_KEYS = 370;    // stop opening new sets past this
    localparam int DRAIN_WAIT  = 80;     // quiet cycles after the last word

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    descending_key_sorter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // words waiting to be driven, filled by the stimulus block
    in_word_t  pending_words[$];
    // sorted words the dut still owes us, oldest first
    out_word_t owed_words[$];

    // predictor state: keys of the set now being loaded
    logic [KEY_W-1:0] held_keys[SET_CAP];
    int               held_count   = 0;
    logic             set_overflow = 1'b0;

    int error_count = 0;
    int keys_queued = 0;

    // store one accepted key; on the closing word sort the set and
    // queue the words the dut must return
    task automatic take_key(input in_word_t w);
        logic [KEY_W-1:0] swap_key;
        out_word_t        ow;
        if (held_count < SET_CAP) begin
            held_keys[held_count] = w.key;
            held_count++;
        end else begin
            // store full, key is lost and the whole set gets flagged
            set_overflow = 1'b1;
        end
        if (w.last_item) begin
            // exchange sort, largest key first
            for (int a = 0; a < held_count; a++) begin
                for (int b = a + 1; b < held_count; b++) begin
                    if (held_keys[a] < held_keys[b]) begin
                        swap_key     = held_keys[a];
                        held_keys[a] = held_keys[b];
                        held_keys[b] = swap_key;
                    end
                end
            end
            for (int i = 0; i < held_count; i++) begin
                ow.sorted_key  = held_keys[i];
                ow.last_result = (i == held_count - 1);
                ow.dropped     = set_overflow;
                owed_words.push_back(ow);
            end
            held_count   = 0;
            set_overflow = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // driver: bursts of random length separated by random gaps
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (s_valid && !s_ready) begin
            // word on the bus not taken yet, hold it steady
        end else begin
            if (s_valid && s_ready) begin
                take_key(s_data);
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_words.pop_front();
                if (burst_left <= 1) begin
                    // new burst; a quarter of the time no gap at all
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each taken output word, stalls on its own pattern
    // ---------------------------------------------------------------
    int mon_cycle = 0;

    always @(posedge aclk) begin
        out_word_t ow;
        mon_cycle <= mon_cycle + 1;
        if (aresetn && m_valid && m_ready) begin
            if (owed_words.size() == 0) begin
                $error("unexpected word: sorted_key %h last_result %b dropped %b",
                       m_data.sorted_key, m_data.last_result, m_data.dropped);
                error_count++;
            end else begin
                ow = owed_words.pop_front();
                if (m_data.sorted_key !== ow.sorted_key) begin
                    $error("sorted_key: expected %h, actual %h",
                           ow.sorted_key, m_data.sorted_key);
                    error_count++;
                end
                if (m_data.last_result !== ow.last_result) begin
                    $error("last_result: expected %b, actual %b",
                           ow.last_result, m_data.last_result);
                    error_count++;
                end
                if (m_data.dropped !== ow.dropped) begin
                    $error("dropped: expected %b, actual %b",
                           ow.dropped, m_data.dropped);
                    error_count++;
                end
            end
        end
        // stall modes rotate: always ready, random stalls, ready one cycle in four
        case ((mon_cycle / 97) % 3)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                m_ready <= ((mon_cycle % 4) == 3);
            end
        endcase
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic add_word(input logic [KEY_W-1:0] k, input logic last);
        in_word_t w;
        w.key       = k;
        w.last_item = last;
        pending_words.push_back(w);
        keys_queued++;
    endtask

    // one closed set of n keys; some keys come from a small pool so
    // equal keys and the extremes show up often
    task automatic add_set(input int n);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0: k = 16'h0000;
                1: k = 16'hFFFF;
                2: k = 16'h1280;
                default: k = KEY_W'($urandom_range(0, 16'hFFFF));
            endcase
            add_word(k, i == n - 1);
        end
    endtask

    initial begin
        int pick;

        // directed: single-key sets at both extremes
        add_word(16'h0000, 1'b1);
        add_word(16'hFFFF, 1'b1);
        // duplicates mixed with the extremes
        add_word(16'h8000, 1'b0);
        add_word(16'hFFFF, 1'b0);
        add_word(16'h0000, 1'b0);
        add_word(16'h8000, 1'b0);
        add_word(16'h0001, 1'b1);
        // already in descending order
        add_word(16'hFFFF, 1'b0);
        add_word(16'h7FFF, 1'b0);
        add_word(16'h0001, 1'b1);
        // ascending order, worst case for the chain
        add_word(16'h0001, 1'b0);
        add_word(16'h0002, 1'b0);
        add_word(16'h8000, 1'b0);
        add_word(16'hFFFE, 1'b1);

        // exactly full store, then an overflowing set whose closing key is lost
        add_set(SET_CAP);
        add_set(SET_CAP + 3);

        // random sets, mostly short, now and then full or overflowing
        while (keys_queued < TARGET_KEYS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                add_set(SET_CAP);
            end else if (pick == 1) begin
                add_set($urandom_range(SET_CAP + 1, SET_CAP + 8));
            end else if (pick == 2) begin
                add_set($urandom_range(9, SET_CAP - 1));
            end else begin
                add_set($urandom_range(1, 8));
            end
        end

        // reset held low, then released on a rising edge
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // all words taken, then every owed word back, then a quiet spell
        wait (pending_words.size() == 0 && !s_valid);
        wait (owed_words.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("descending_key_sorter verification clean");
        end else begin
            $display("descending_key_sorter verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #400000;
        $display("descending_key_sorter verification failed");
        $finish;
    end

endmodule
